// ----- rtl/mlk_pkg.sv -----
package mlk_pkg;

    localparam int MAX_SYMBOLS = 5;
    localparam int COUNT_BITS  = 16;
    localparam int CHAR_COUNT  = 36;
    localparam int CFG_W       = 16;
    localparam int PAT_W       = 5;
    localparam int LEN_W       = 3;
    localparam int IDX_W       = 6;

    localparam logic [32:0] CntMax = (33'd1 << COUNT_BITS) - 33'd1;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_DOT  = 2'd0,
        CFG_DASH = 2'd1,
        CFG_GAP  = 2'd2
    } t_cfg_idx;

    typedef logic [COUNT_BITS-1:0] t_count;

    // bits 7..5 length, bits 4..0 pattern, bit 0 sent first, 1 = dash
    function automatic logic [7:0] code_rom(input logic [IDX_W-1:0] idx);
        logic [7:0] e;
        case (idx)
            6'd0:    e = {3'd2, 5'd2};
            6'd1:    e = {3'd4, 5'd1};
            6'd2:    e = {3'd4, 5'd5};
            6'd3:    e = {3'd3, 5'd1};
            6'd4:    e = {3'd1, 5'd0};
            6'd5:    e = {3'd4, 5'd4};
            6'd6:    e = {3'd3, 5'd3};
            6'd7:    e = {3'd4, 5'd0};
            6'd8:    e = {3'd2, 5'd0};
            6'd9:    e = {3'd4, 5'd14};
            6'd10:   e = {3'd3, 5'd5};
            6'd11:   e = {3'd4, 5'd2};
            6'd12:   e = {3'd2, 5'd3};
            6'd13:   e = {3'd2, 5'd1};
            6'd14:   e = {3'd3, 5'd7};
            6'd15:   e = {3'd4, 5'd6};
            6'd16:   e = {3'd4, 5'd11};
            6'd17:   e = {3'd3, 5'd2};
            6'd18:   e = {3'd3, 5'd0};
            6'd19:   e = {3'd1, 5'd1};
            6'd20:   e = {3'd3, 5'd4};
            6'd21:   e = {3'd4, 5'd8};
            6'd22:   e = {3'd3, 5'd6};
            6'd23:   e = {3'd4, 5'd9};
            6'd24:   e = {3'd4, 5'd13};
            6'd25:   e = {3'd4, 5'd3};
            6'd26:   e = {3'd5, 5'd31};
            6'd27:   e = {3'd5, 5'd30};
            6'd28:   e = {3'd5, 5'd28};
            6'd29:   e = {3'd5, 5'd24};
            6'd30:   e = {3'd5, 5'd16};
            6'd31:   e = {3'd5, 5'd0};
            6'd32:   e = {3'd5, 5'd1};
            6'd33:   e = {3'd5, 5'd3};
            6'd34:   e = {3'd5, 5'd7};
            6'd35:   e = {3'd5, 5'd15};
            default: e = 8'd0;
        endcase
        return e;
    endfunction

    // zero counts as one tick, large values saturate at the counter maximum
    function automatic t_count clamp_ticks(input logic [CFG_W-1:0] v);
        logic [32:0] x;
        t_count      r;
        x = {{(33-CFG_W){1'b0}}, v};
        if (x == 33'd0) begin
            r = t_count'(1);
        end else if (x > CntMax) begin
            r = CntMax[COUNT_BITS-1:0];
        end else begin
            r = x[COUNT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/morse_led_keyer_core.sv -----
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_axis_tvalid/o_..ready  tdata[5:0] char_index, tuser operation
// m_axis    out  o_m_axis_tvalid/i_..ready  tdata led_on,busy_res,rejected; tlast
// cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while the output is not stalled; each passes
// the input register, then state update and result register.
// Synchronous active-low reset: idle, LED dark, timing registers 250/600/250.
// A stalled output holds the pipe; the input register refills as soon as
// the result register is free or being drained.
module morse_led_keyer_core
    import mlk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [5:0] char_index, [7:6] zero
    input  logic                i_s_axis_tuser,   // [0] operation
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [7:0]          o_m_axis_tdata,   // [0] led_on, [1] busy_res,
                                                  // [2] rejected, [7:3] zero
    output logic                o_m_axis_tlast,   // char_done
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    logic [CFG_W-1:0] r_dot, r_dash, r_gap;

    logic             r_in_valid;
    t_op              r_in_op;
    logic [IDX_W-1:0] r_in_idx;

    logic             r_out_valid;
    logic             r_out_led, r_out_busy, r_out_done, r_out_rej;

    logic [PAT_W-1:0] r_pat, n_pat;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_gap_ph, n_gap_ph;
    t_count           r_cnt, n_cnt;
    logic             r_active, n_active;
    logic             n_done, n_rej;

    logic             advance;
    logic [7:0]       rom_e;
    logic [LEN_W-1:0] rom_len;
    t_count           dur;
    t_count           cnt_inc;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= CFG_W'(250);
            r_dash <= CFG_W'(600);
            r_gap  <= CFG_W'(250);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DOT:  r_dot  <= i_cfg_data;
                CFG_DASH: r_dash <= i_cfg_data;
                CFG_GAP:  r_gap  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op  <= t_op'(i_s_axis_tuser);
            r_in_idx <= i_s_axis_tdata[IDX_W-1:0];
        end
    end

    always_comb begin
        rom_e   = code_rom(r_in_idx);
        rom_len = rom_e[7:5];
        if (int'(rom_len) > MAX_SYMBOLS) begin
            rom_len = LEN_W'(MAX_SYMBOLS);
        end
        if (r_gap_ph) begin
            dur = clamp_ticks(r_gap);
        end else if (r_pat[0]) begin
            dur = clamp_ticks(r_dash);
        end else begin
            dur = clamp_ticks(r_dot);
        end
        cnt_inc = (r_cnt != CntMax[COUNT_BITS-1:0]) ? r_cnt + t_count'(1) : r_cnt;

        n_pat    = r_pat;
        n_left   = r_left;
        n_gap_ph = r_gap_ph;
        n_cnt    = r_cnt;
        n_active = r_active;
        n_done   = 1'b0;
        n_rej    = 1'b0;

        case (r_in_op)
            OP_START: begin
                if (r_active || (int'(r_in_idx) >= CHAR_COUNT)) begin
                    n_rej = 1'b1;
                end else begin
                    n_pat    = rom_e[PAT_W-1:0];
                    n_left   = rom_len;
                    n_gap_ph = 1'b0;
                    n_cnt    = '0;
                    n_active = (rom_len != '0);
                end
            end
            OP_TICK: begin
                if (r_active) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= dur) begin
                        n_cnt = '0;
                        if (!r_gap_ph) begin
                            n_gap_ph = 1'b1;
                        end else begin
                            n_gap_ph = 1'b0;
                            n_pat    = r_pat >> 1;
                            n_left   = r_left - LEN_W'(1);
                            if (n_left == '0) begin
                                n_active = 1'b0;
                                n_pat    = '0;
                                n_done   = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= '0;
            r_left      <= '0;
            r_gap_ph    <= 1'b0;
            r_cnt       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_pat    <= n_pat;
                r_left   <= n_left;
                r_gap_ph <= n_gap_ph;
                r_cnt    <= n_cnt;
                r_active <= n_active;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_led  <= n_active && !n_gap_ph;
            r_out_busy <= n_active;
            r_out_done <= n_done;
            r_out_rej  <= n_rej;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_rej, r_out_busy, r_out_led};
    assign o_m_axis_tlast  = r_out_done;

    a_active_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_left != '0))
        else $error("active flag disagrees with symbol count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> !o_m_axis_tdata[1])
        else $error("char_done while still busy");

    a_led_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> o_m_axis_tdata[1])
        else $error("LED lit while idle");

    a_done_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tlast && o_m_axis_tdata[2]))
        else $error("char_done and rejected together");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_active) && $stable(r_cnt)))
        else $error("keyer state moved without a transaction");

endmodule

// ----- tb/sv/tb_morse_led_keyer_core.sv -----
`timescale 1ns / 1ps

module tb_morse_led_keyer_core;
    import mlk_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1250;

    typedef struct packed {
        logic led_on;
        logic busy;
        logic char_done;
        logic rejected;
    } t_led_state;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata;   // [5:0] char_index, [7:6] zero
    logic             i_s_axis_tuser;   // [0] operation
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [7:0]       o_m_axis_tdata;   // [0] led_on, [1] busy_res, [2] rejected
    logic             o_m_axis_tlast;   // char_done
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    morse_led_keyer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // {length, pattern}; pattern bit 0 keyed first, 1 = dash
    logic [7:0] morse_rom [CHAR_COUNT] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},
        {3'd1, 5'd0},  {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},
        {3'd2, 5'd0},  {3'd4, 5'd14}, {3'd3, 5'd5},  {3'd4, 5'd2},
        {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},  {3'd4, 5'd6},
        {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},
        {3'd4, 5'd13}, {3'd4, 5'd3},
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24},
        {3'd5, 5'd16}, {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},
        {3'd5, 5'd7},  {3'd5, 5'd15}
    };

    // keyer state as predicted
    logic [CFG_W-1:0] dot_len, dash_len, gap_len;
    logic [PAT_W-1:0] sym_bits;
    logic [LEN_W-1:0] sym_left;
    logic             dark;
    t_count           phase_cnt;
    logic             keying;

    t_led_state led_state_q [$];
    int         err_cnt      = 0;
    int         sent_items   = 0;
    int         quiet_cycles = 0;
    int         burst_left   = 0;
    int         hold_left    = 0;
    bit         hold_req     = 0;
    int         rx_mode      = 0;
    int         rx_phase     = 0;
    t_led_state got_state, want_state;

    function automatic t_count ticks_of(input logic [CFG_W-1:0] v);
        logic [32:0] lim;
        lim = (33'd1 << COUNT_BITS) - 33'd1;
        if (v == '0)
            return t_count'(1);
        if ({17'd0, v} > lim)
            return lim[COUNT_BITS-1:0];
        return t_count'(v);
    endfunction

    task automatic predict_led_state(input t_op op, input logic [IDX_W-1:0] idx);
        t_led_state r;
        t_count     span;
        logic [7:0] code;
        r = '0;
        if (op == OP_START) begin
            if (keying || idx >= CHAR_COUNT) begin
                r.rejected = 1'b1;
            end else begin
                code      = morse_rom[idx];
                sym_bits  = code[4:0];
                sym_left  = (code[7:5] > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS) : code[7:5];
                dark      = 1'b0;
                phase_cnt = '0;
                keying    = (sym_left != '0);
            end
        end else if (keying) begin
            if (dark)
                span = ticks_of(gap_len);
            else if (sym_bits[0])
                span = ticks_of(dash_len);
            else
                span = ticks_of(dot_len);
            if (phase_cnt != '1)
                phase_cnt = phase_cnt + 1'b1;
            if (phase_cnt >= span) begin
                phase_cnt = '0;
                if (!dark) begin
                    dark = 1'b1;
                end else begin
                    dark     = 1'b0;
                    sym_bits = sym_bits >> 1;
                    sym_left = sym_left - 1'b1;
                    if (sym_left == '0) begin
                        keying      = 1'b0;
                        sym_bits    = '0;
                        r.char_done = 1'b1;
                    end
                end
            end
        end
        r.led_on = keying && !dark;
        r.busy   = keying;
        sent_items++;
        led_state_q.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_item(input t_op op, input logic [IDX_W-1:0] idx);
        int pause;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, idx};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        predict_led_state(op, idx);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pause      = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (pause != 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (pause - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, IDX_W'($urandom));
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (led_state_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx r, input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (r)
            CFG_DOT:  dot_len  = v;
            CFG_DASH: dash_len = v;
            default:  gap_len  = v;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] g);
        write_cfg(CFG_DOT, d);
        write_cfg(CFG_DASH, h);
        write_cfg(CFG_GAP, g);
    endtask

    task automatic key_out();
        while (keying)
            send_tick();
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (keying) begin
            if (pick < 88)
                send_tick();
            else
                send_item(OP_START, IDX_W'($urandom));
        end else if (pick < 70) begin
            send_item(OP_START, IDX_W'($urandom_range(0, CHAR_COUNT - 1)));
        end else if (pick < 82) begin
            send_item(OP_START, IDX_W'($urandom_range(CHAR_COUNT, 63)));
        end else begin
            send_tick();
        end
    endtask

    // idle ticks, bad index, busy start; zero timing written mid-character
    task automatic test_idle_and_reject();
        send_tick();
        send_item(OP_START, IDX_W'(CHAR_COUNT));
        send_item(OP_START, '1);
        send_item(OP_START, IDX_W'(4));
        repeat (3) send_tick();
        send_item(OP_START, '0);
        wait_results();
        write_cfg(CFG_DOT, '0);
        write_cfg(CFG_GAP, '0);
        send_tick();
        send_tick();
        send_tick();
        wait_results();
    endtask

    // longest timings, then shortened while a character is in flight
    task automatic test_long_symbols();
        set_timing('1, '1, '1);
        send_item(OP_START, IDX_W'(CHAR_COUNT - 1));
        repeat (4) send_tick();
        wait_results();
        set_timing(16'd1, 16'd2, 16'd1);
        key_out();
        send_item(OP_START, '0);
        key_out();
        wait_results();
    endtask

    // output held off long enough to back up the pipe
    task automatic test_output_hold();
        set_timing(16'd1, 16'd2, 16'd1);
        hold_req = 1'b1;
        repeat (40) send_random_item();
        wait_results();
    endtask

    task automatic test_random_keying();
        int kind;
        while (sent_items < RANDOM_ITEMS) begin
            wait_results();
            kind = $urandom_range(0, 9);
            case (kind)
                0:       set_timing(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                1:       set_timing('0, '0, '0);
                2:       set_timing(16'd250, 16'd600, 16'd250);
                default: set_timing(CFG_W'($urandom_range(1, 5)), CFG_W'($urandom_range(1, 6)),
                                    CFG_W'($urandom_range(1, 5)));
            endcase
            repeat ($urandom_range(40, 100)) send_random_item();
        end
    endtask

    // receiver: stall pattern re-chosen at random from four modes; full hold on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (rx_phase == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_phase = $urandom_range(20, 80);
        end else begin
            rx_phase--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       i_m_axis_tready <= ($urandom_range(0, 2) == 0);
                default: i_m_axis_tready <= rx_phase[2];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_state = {o_m_axis_tdata[0], o_m_axis_tdata[1], o_m_axis_tlast, o_m_axis_tdata[2]};
            if (led_state_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("%0t: unexpected transaction led=%b busy=%b done=%b rej=%b",
                             $realtime, got_state.led_on, got_state.busy,
                             got_state.char_done, got_state.rejected);
            end else begin
                want_state = led_state_q.pop_front();
                if (got_state.led_on !== want_state.led_on ||
                    got_state.busy !== want_state.busy ||
                    got_state.char_done !== want_state.char_done ||
                    got_state.rejected !== want_state.rejected) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display({"%0t: mismatch exp led=%b busy=%b done=%b rej=%b",
                                  " got led=%b busy=%b done=%b rej=%b"}, $realtime,
                                 want_state.led_on, want_state.busy,
                                 want_state.char_done, want_state.rejected,
                                 got_state.led_on, got_state.busy,
                                 got_state.char_done, got_state.rejected);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        dot_len   = 16'd250;
        dash_len  = 16'd600;
        gap_len   = 16'd250;
        sym_bits  = '0;
        sym_left  = '0;
        dark      = 1'b0;
        phase_cnt = '0;
        keying    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_idle_and_reject();
        test_long_symbols();
        test_output_hold();
        test_random_keying();

        wait_results();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && led_state_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
